// ===== hw/rtl/partial_area_rotation_scatter_unit_defines.svh =====
// Assertion helpers for the rotation scatter unit.
// Both macros sample on clk and are disabled while rst is high.
`ifndef PARTIAL_AREA_ROTATION_SCATTER_UNIT_DEFINES_SVH
`define PARTIAL_AREA_ROTATION_SCATTER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PARS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PARS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pars_pkg.sv =====
`default_nettype none

package pars_pkg;

  // Largest display side; coordinates wrap modulo this value
  localparam int MAX_SIDE = 1024;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int SIZE_W   = COORD_W + 1;
  localparam int INDEX_W  = COORD_W + SIZE_W;
  localparam int COLOR_W  = 16;
  localparam int STEP_W   = 5;
  localparam int MAX_STEP = 16;
  localparam int REM_W    = $clog2(MAX_STEP);
  localparam int COUNT_W  = $clog2(SIZE_W);

  // Stream payload widths
  localparam int IN_FIELDS_W  = 4 * COORD_W + COLOR_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * COORD_W + 2 * SIZE_W + INDEX_W + COLOR_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_ROTATION = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROUNDING = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCR_W    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SCR_H    = 2'd3;

  // Item kinds on both sides
  localparam logic KIND_AREA  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_90   = 2'd1,
    ROT_180  = 2'd2,
    ROT_270  = 2'd3
  } rot_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_HDR,
    ST_MUL,
    ST_PIX
  } ctrl_state_t;

  typedef struct packed {
    rot_mode_t           rotation_mode;
    logic [STEP_W-1:0]   rounding_step;
    logic [SIZE_W-1:0]   screen_width;
    logic [SIZE_W-1:0]   screen_height;
  } pars_cfg_t;

  typedef struct packed {
    logic accept_hdr;
    logic accept_pix;
    logic div_step;
    logic mul_step;
    logic load_hdr;
    logic load_pix;
  } pars_cmd_t;

  typedef struct packed {
    logic out_free;
  } pars_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pars_regs.sv =====
`default_nettype none

module pars_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pars_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [pars_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [pars_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  output pars_pkg::pars_cfg_t                 cfg
);
  import pars_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[REG_IDX_W+1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation_mode <= ROT_NONE;
      cfg.rounding_step <= STEP_W'(1);
      cfg.screen_width  <= SIZE_W'(240);
      cfg.screen_height <= SIZE_W'(240);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROTATION: cfg.rotation_mode <= rot_mode_t'(pwdata[1:0]);
        REG_ROUNDING: cfg.rounding_step <= pwdata[STEP_W-1:0];
        REG_SCR_W:    cfg.screen_width  <= pwdata[SIZE_W-1:0];
        REG_SCR_H:    cfg.screen_height <= pwdata[SIZE_W-1:0];
        default:      ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_ROTATION: prdata = APB_DATA_W'(cfg.rotation_mode);
      REG_ROUNDING: prdata = APB_DATA_W'(cfg.rounding_step);
      REG_SCR_W:    prdata = APB_DATA_W'(cfg.screen_width);
      REG_SCR_H:    prdata = APB_DATA_W'(cfg.screen_height);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pars_ctrl.sv =====
`default_nettype none

module pars_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_kind,
  output logic                   in_ready,
  input  pars_pkg::pars_status_t status,
  output pars_pkg::pars_cmd_t    cmd
);
  import pars_pkg::*;

  localparam logic [COUNT_W-1:0] DIV_LAST = COUNT_W'(SIZE_W - 1);

  ctrl_state_t        state;
  ctrl_state_t        state_next;
  logic [COUNT_W-1:0] div_count;

  // State register and remainder step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_count <= '0;
    end else begin
      state <= state_next;
      if (cmd.accept_hdr) begin
        div_count <= DIV_LAST;
      end else if (cmd.div_step && div_count != '0) begin
        div_count <= div_count - COUNT_W'(1);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_kind == KIND_AREA) ? ST_DIV : ST_MUL;
        end
      end
      ST_DIV: begin
        if (div_count == '0) state_next = ST_HDR;
      end
      ST_HDR: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      ST_MUL: state_next = ST_PIX;
      ST_PIX: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_ready       = (state == ST_IDLE);
    cmd.accept_hdr = (state == ST_IDLE) && in_valid && (in_kind == KIND_AREA);
    cmd.accept_pix = (state == ST_IDLE) && in_valid && (in_kind == KIND_PIXEL);
    cmd.div_step   = (state == ST_DIV);
    cmd.mul_step   = (state == ST_MUL);
    cmd.load_hdr   = (state == ST_HDR) && status.out_free;
    cmd.load_pix   = (state == ST_PIX) && status.out_free;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pars_dp.sv =====
`default_nettype none

module pars_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  pars_pkg::pars_cfg_t               cfg,
  input  pars_pkg::pars_cmd_t               cmd,
  output pars_pkg::pars_status_t            status,
  input  wire logic [pars_pkg::COORD_W-1:0] in_left,
  input  wire logic [pars_pkg::COORD_W-1:0] in_top,
  input  wire logic [pars_pkg::COORD_W-1:0] in_right,
  input  wire logic [pars_pkg::COORD_W-1:0] in_bottom,
  input  wire logic [pars_pkg::COLOR_W-1:0] in_color,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic                              result_kind,
  output logic      [pars_pkg::COORD_W-1:0] out_x,
  output logic      [pars_pkg::COORD_W-1:0] out_y,
  output logic      [pars_pkg::SIZE_W-1:0]  out_width,
  output logic      [pars_pkg::SIZE_W-1:0]  out_height,
  output logic      [pars_pkg::INDEX_W-1:0] dest_index,
  output logic      [pars_pkg::COLOR_W-1:0] out_color
);
  import pars_pkg::*;

  // Area state
  logic [COORD_W-1:0] area_left;
  logic [COORD_W-1:0] area_top;
  logic [SIZE_W-1:0]  area_width;
  logic [SIZE_W-1:0]  area_height;
  logic [SIZE_W-1:0]  padded_height;
  logic [COORD_W-1:0] source_row;
  logic [COORD_W-1:0] source_col;

  // Remainder unit
  logic [SIZE_W-1:0]  div_shift;
  logic [REM_W-1:0]   div_rem;

  // Pixel pipeline
  logic [INDEX_W-1:0] prod;
  logic [COORD_W-1:0] addend;
  logic [COLOR_W-1:0] pix_color;

  logic [SIZE_W-1:0]  span_w;
  logic [SIZE_W-1:0]  span_h;
  logic [STEP_W-1:0]  step_eff;
  logic [STEP_W-1:0]  trial;
  logic               trial_ge;
  logic [STEP_W-1:0]  pad_add;
  logic [SIZE_W-1:0]  hr_calc;
  logic [COORD_W-1:0] flip_x;
  logic [COORD_W-1:0] flip_y;
  logic [COORD_W-1:0] hdr_x;
  logic [COORD_W-1:0] hdr_y;
  logic [SIZE_W-1:0]  hdr_w;
  logic [SIZE_W-1:0]  hdr_h;
  logic [COORD_W-1:0] mirror_h;
  logic [COORD_W-1:0] mirror_w;
  logic [COORD_W-1:0] mul_a;
  logic [SIZE_W-1:0]  mul_b;
  logic [COORD_W-1:0] mul_add;
  logic [SIZE_W-1:0]  col_inc;
  logic [SIZE_W-1:0]  row_inc;

  // Inclusive spans, zero when reversed
  assign span_w = (in_right >= in_left) ?
                  SIZE_W'(in_right) - SIZE_W'(in_left) + SIZE_W'(1) : '0;
  assign span_h = (in_bottom >= in_top) ?
                  SIZE_W'(in_bottom) - SIZE_W'(in_top) + SIZE_W'(1) : '0;

  // Clamp rounding step to 1..16
  always_comb begin
    priority if (cfg.rounding_step == '0) begin
      step_eff = STEP_W'(1);
    end else if (cfg.rounding_step > STEP_W'(MAX_STEP)) begin
      step_eff = STEP_W'(MAX_STEP);
    end else begin
      step_eff = cfg.rounding_step;
    end
  end

  // One restoring remainder step per cycle, height MSB first
  assign trial    = {div_rem, div_shift[SIZE_W-1]};
  assign trial_ge = (trial >= step_eff);

  // Round height up: add step minus remainder when not exact
  assign pad_add = (div_rem == '0) ? '0 : step_eff - STEP_W'(div_rem);
  assign hr_calc = area_height + SIZE_W'(pad_add);

  // Rotated origin and size
  assign flip_x = cfg.screen_height[COORD_W-1:0] - area_top - area_height[COORD_W-1:0];
  assign flip_y = cfg.screen_width[COORD_W-1:0] - area_left - area_width[COORD_W-1:0];

  always_comb begin
    unique case (cfg.rotation_mode)
      ROT_90: begin
        hdr_x = flip_x;    hdr_y = area_left;
        hdr_w = hr_calc;   hdr_h = area_width;
      end
      ROT_180: begin
        hdr_x = flip_y;    hdr_y = flip_x;
        hdr_w = area_width; hdr_h = area_height;
      end
      ROT_270: begin
        hdr_x = area_top;  hdr_y = flip_y;
        hdr_w = hr_calc;   hdr_h = area_width;
      end
      default: begin
        hdr_x = area_left; hdr_y = area_top;
        hdr_w = area_width; hdr_h = area_height;
      end
    endcase
  end

  // Mirrored coordinates wrap modulo the side limit
  assign mirror_h = area_height[COORD_W-1:0] - COORD_W'(1) - source_row;
  assign mirror_w = area_width[COORD_W-1:0] - COORD_W'(1) - source_col;

  // Multiplier operands for the destination index
  always_comb begin
    unique case (cfg.rotation_mode)
      ROT_90: begin
        mul_a = source_col; mul_b = padded_height; mul_add = mirror_h;
      end
      ROT_180: begin
        mul_a = mirror_h;   mul_b = area_width;    mul_add = mirror_w;
      end
      ROT_270: begin
        mul_a = mirror_w;   mul_b = padded_height; mul_add = source_row;
      end
      default: begin
        mul_a = source_row; mul_b = area_width;    mul_add = source_col;
      end
    endcase
  end

  assign col_inc = SIZE_W'(source_col) + SIZE_W'(1);
  assign row_inc = SIZE_W'(source_row) + SIZE_W'(1);

  // Area sizes, padded height and source position
  always_ff @(posedge clk) begin
    if (rst) begin
      area_width    <= '0;
      area_height   <= '0;
      padded_height <= '0;
      source_row    <= '0;
      source_col    <= '0;
    end else begin
      if (cmd.accept_hdr) begin
        area_width  <= span_w;
        area_height <= span_h;
        source_row  <= '0;
        source_col  <= '0;
      end
      if (cmd.load_hdr) begin
        padded_height <= hr_calc;
      end
      // Advance source position, wrapping inside the area
      if (cmd.mul_step) begin
        if (col_inc >= area_width) begin
          source_col <= '0;
          source_row <= (row_inc >= area_height) ? '0 : row_inc[COORD_W-1:0];
        end else begin
          source_col <= col_inc[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_hdr) begin
      area_left <= in_left;
      area_top  <= in_top;
      div_shift <= span_h;
      div_rem   <= '0;
    end else if (cmd.div_step) begin
      div_shift <= div_shift << 1;
      div_rem   <= trial_ge ? REM_W'(trial - step_eff) : trial[REM_W-1:0];
    end
    if (cmd.accept_pix) begin
      pix_color <= in_color;
    end
    if (cmd.mul_step) begin
      prod   <= INDEX_W'(mul_a) * INDEX_W'(mul_b);
      addend <= mul_add;
    end
  end

  // Output register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_hdr || cmd.load_pix) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hdr) begin
      result_kind <= KIND_AREA;
      out_x       <= hdr_x;
      out_y       <= hdr_y;
      out_width   <= hdr_w;
      out_height  <= hdr_h;
      dest_index  <= '0;
      out_color   <= '0;
    end else if (cmd.load_pix) begin
      result_kind <= KIND_PIXEL;
      out_x       <= '0;
      out_y       <= '0;
      out_width   <= '0;
      out_height  <= '0;
      dest_index  <= prod + INDEX_W'(addend);
      out_color   <= pix_color;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/partial_area_rotation_scatter_unit.sv =====
// Area-start item: the 11-step remainder loop that rounds the height up runs
//   before the header state loads the result into the output register.
// Pixel item: operand select and multiply are registered, then the add loads the
//   output register; a new item is taken only after the last one is loaded.
// One item is in flight at a time; a finished result waits in the output register.
// Reset (rst, synchronous) returns registers to defaults and clears area sizes and source position.
`default_nettype none

`include "partial_area_rotation_scatter_unit_defines.svh"

module partial_area_rotation_scatter_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // left[9:0], top[19:10], right[29:20], bottom[39:30], color[55:40]
  input  wire logic [pars_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // kind[0]
  input  wire logic                             s_axis_tuser,
  // Result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // out_x[9:0], out_y[19:10], out_width[30:20], out_height[41:31],
  // dest_index[62:42], out_color[78:63], zero[79]
  output logic      [pars_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // result_kind[0]
  output logic                                  m_axis_tuser,
  // Configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pars_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [pars_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [pars_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import pars_pkg::*;

  pars_cfg_t          cfg;
  pars_cmd_t          cmd;
  pars_status_t       status;

  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [SIZE_W-1:0]  out_width;
  logic [SIZE_W-1:0]  out_height;
  logic [INDEX_W-1:0] dest_index;
  logic [COLOR_W-1:0] out_color;

  pars_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pars_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pars_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .in_left     (s_axis_tdata[COORD_W-1:0]),
    .in_top      (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .in_right    (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
    .in_bottom   (s_axis_tdata[4*COORD_W-1:3*COORD_W]),
    .in_color    (s_axis_tdata[4*COORD_W+COLOR_W-1:4*COORD_W]),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .result_kind (m_axis_tuser),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_width   (out_width),
    .out_height  (out_height),
    .dest_index  (dest_index),
    .out_color   (out_color)
  );

  // Pack result fields, lowest first
  assign m_axis_tdata = OUT_TDATA_W'({out_color, dest_index, out_height, out_width,
                                      out_y, out_x});

  // One transaction at a time: input closes right after an acceptance
  `PARS_ASSERT_NEXT(a_single_item, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                    "input accepted while an item is in flight")

  // Output register is loaded only when it is empty or draining
  `PARS_ASSERT_SAME(a_no_overwrite, cmd.load_hdr || cmd.load_pix,
                    !m_axis_tvalid || m_axis_tready,
                    "result register overwritten before transfer")

  // A taken result with no reload leaves the output empty
  `PARS_ASSERT_NEXT(a_drain, m_axis_tvalid && m_axis_tready && !cmd.load_hdr && !cmd.load_pix,
                    !m_axis_tvalid, "result repeated after transfer")

endmodule

`default_nettype wire

// ===== test/tb_partial_area_rotation_scatter_unit.sv =====
// One expected or observed result transaction, field by field
typedef struct {
  logic        kind;
  logic [9:0]  x;
  logic [9:0]  y;
  logic [10:0] width;
  logic [10:0] height;
  logic [20:0] index;
  logic [15:0] color;
} placement_t;

// Tracks area geometry and predicts where each pixel lands in the rotated buffer
class rotation_scoreboard;
  pars_pkg::rot_mode_t mode;
  logic [31:0] step_reg;
  logic [31:0] scr_w;
  logic [31:0] scr_h;
  logic [31:0] area_w;
  logic [31:0] area_h;
  logic [31:0] pad_h;
  logic [31:0] row;
  logic [31:0] col;
  placement_t  placements_q[$];
  int unsigned errors;
  int unsigned areas_seen;
  int unsigned pixels_seen;

  function new();
    mode     = pars_pkg::ROT_NONE;
    step_reg = 1;
    scr_w    = 240;
    scr_h    = 240;
    area_w   = 0;
    area_h   = 0;
    pad_h    = 0;
    row      = 0;
    col      = 0;
    errors   = 0;
    areas_seen  = 0;
    pixels_seen = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      pars_pkg::REG_ROTATION: mode = pars_pkg::rot_mode_t'(value[1:0]);
      pars_pkg::REG_ROUNDING: step_reg = {27'd0, value[4:0]};
      pars_pkg::REG_SCR_W:    scr_w = {21'd0, value[10:0]};
      pars_pkg::REG_SCR_H:    scr_h = {21'd0, value[10:0]};
      default: ;
    endcase
  endfunction

  // Reflect a position within a side, wrapping modulo the largest side
  function logic [31:0] flip(logic [31:0] size, logic [31:0] pos);
    return ((size % pars_pkg::MAX_SIDE) + 2 * pars_pkg::MAX_SIDE - 1
            - (pos % pars_pkg::MAX_SIDE)) % pars_pkg::MAX_SIDE;
  endfunction

  function int pending();
    return placements_q.size();
  endfunction

  // Note an accepted input transaction and queue the result it causes
  function void note_input(logic kind, logic [pars_pkg::IN_TDATA_W-1:0] data);
    placement_t  want;
    logic [31:0] lft, tp, rgt, bot, s, w, h, hr, ox, oy, ow, oh, idx;
    want = '{default: '0};
    want.kind = kind;
    if (kind == pars_pkg::KIND_AREA) begin
      lft = {22'd0, data[9:0]};
      tp  = {22'd0, data[19:10]};
      rgt = {22'd0, data[29:20]};
      bot = {22'd0, data[39:30]};
      s = step_reg;
      if (s == 0) s = 1;
      if (s > pars_pkg::MAX_STEP) s = pars_pkg::MAX_STEP;
      w  = (rgt >= lft) ? rgt - lft + 1 : 0;
      h  = (bot >= tp) ? bot - tp + 1 : 0;
      hr = (h + s - 1) / s * s;
      area_w = w & 32'h7FF;
      area_h = h & 32'h7FF;
      pad_h  = hr & 32'h7FF;
      row = 0;
      col = 0;
      case (mode)
        pars_pkg::ROT_90: begin
          ox = scr_h - tp - h;
          oy = lft;
          ow = hr;
          oh = w;
        end
        pars_pkg::ROT_180: begin
          ox = scr_w - lft - w;
          oy = scr_h - tp - h;
          ow = w;
          oh = h;
        end
        pars_pkg::ROT_270: begin
          ox = tp;
          oy = scr_w - lft - w;
          ow = hr;
          oh = w;
        end
        default: begin
          ox = lft;
          oy = tp;
          ow = w;
          oh = h;
        end
      endcase
      want.x      = ox[9:0];
      want.y      = oy[9:0];
      want.width  = ow[10:0];
      want.height = oh[10:0];
      areas_seen++;
    end else begin
      case (mode)
        pars_pkg::ROT_90:  idx = col * pad_h + flip(area_h, row);
        pars_pkg::ROT_180: idx = flip(area_h, row) * area_w + flip(area_w, col);
        pars_pkg::ROT_270: idx = flip(area_w, col) * pad_h + row;
        default:           idx = row * area_w + col;
      endcase
      want.index = idx[20:0];
      want.color = data[55:40];
      // advance the source position, wrapping inside the area
      if (col + 1 >= area_w) begin
        col = 0;
        row = (row + 1 >= area_h) ? 0 : ((row + 1) & 32'h3FF);
      end else begin
        col = (col + 1) & 32'h3FF;
      end
      pixels_seen++;
    end
    placements_q = {placements_q, want};
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare an accepted result transaction with the oldest expectation
  function void check_result(logic kind, logic [pars_pkg::OUT_TDATA_W-1:0] data);
    placement_t want;
    if (placements_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual kind %0d data %h",
               $time, kind, data);
      return;
    end
    want = placements_q.pop_front();
    check_field("result_kind", 32'(want.kind),   32'(kind));
    check_field("out_x",       32'(want.x),      32'(data[9:0]));
    check_field("out_y",       32'(want.y),      32'(data[19:10]));
    check_field("out_width",   32'(want.width),  32'(data[30:20]));
    check_field("out_height",  32'(want.height), 32'(data[41:31]));
    check_field("dest_index",  32'(want.index),  32'(data[62:42]));
    check_field("out_color",   32'(want.color),  32'(data[78:63]));
  endfunction
endclass

module tb_partial_area_rotation_scatter_unit;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  // left[9:0], top[19:10], right[29:20], bottom[39:30], color[55:40]
  logic [pars_pkg::IN_TDATA_W-1:0]    s_axis_tdata;
  // kind[0]
  logic                               s_axis_tuser;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  // out_x[9:0], out_y[19:10], out_width[30:20], out_height[41:31],
  // dest_index[62:42], out_color[78:63]
  logic [pars_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
  // result_kind[0]
  logic                               m_axis_tuser;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [pars_pkg::APB_ADDR_W-1:0]    paddr;
  logic [pars_pkg::APB_DATA_W-1:0]    pwdata;
  logic [pars_pkg::APB_DATA_W-1:0]    prdata;
  logic                               pready;

  rotation_scoreboard sb;
  int send_streak;
  int sink_streak;

  // Fixed register settings for the first phases, extremes included
  pars_pkg::rot_mode_t phase_rot [6] = '{pars_pkg::ROT_90, pars_pkg::ROT_180,
                                         pars_pkg::ROT_270, pars_pkg::ROT_NONE,
                                         pars_pkg::ROT_90, pars_pkg::ROT_270};
  int unsigned phase_step [6] = '{16, 0, 31, 1, 3, 7};
  int unsigned phase_sw   [6] = '{1024, 1, 2047, 0, 240, 333};
  int unsigned phase_sh   [6] = '{1, 1024, 0, 2047, 320, 777};

  partial_area_rotation_scatter_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // Idle cycles before the next transaction, with occasional runs of none
  function automatic int draw_gap(ref int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      streak = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic send_item(input logic kind, input logic [9:0] lft, input logic [9:0] tp,
                           input logic [9:0] rgt, input logic [9:0] bot,
                           input logic [15:0] color);
    int gap;
    gap = draw_gap(send_streak);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= pars_pkg::IN_TDATA_W'({color, bot, rgt, tp, lft});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(kind, pars_pkg::IN_TDATA_W'({color, bot, rgt, tp, lft}));
  endtask

  task automatic send_area(input int unsigned lft, input int unsigned tp,
                           input int unsigned rgt, input int unsigned bot);
    send_item(pars_pkg::KIND_AREA, lft[9:0], tp[9:0], rgt[9:0], bot[9:0],
              16'($urandom_range(0, 16'hFFFF)));
  endtask

  // Coordinate bits are ignored for pixels; fill them with noise
  task automatic send_pixel(input logic [15:0] color);
    send_item(pars_pkg::KIND_PIXEL, 10'($urandom), 10'($urandom), 10'($urandom),
              10'($urandom), color);
  endtask

  // Hold the input side until every queued result has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic program_settings(input pars_pkg::rot_mode_t rot, input int unsigned step,
                                  input int unsigned sw, input int unsigned sh);
    write_reg(pars_pkg::REG_ROTATION, 32'(rot));
    write_reg(pars_pkg::REG_ROUNDING, step);
    write_reg(pars_pkg::REG_SCR_W, sw);
    write_reg(pars_pkg::REG_SCR_H, sh);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed areas with their pixels, plus odd rectangles and stray pixels
  task automatic run_phase(input int unsigned n_items);
    int unsigned sent, w, h, tmp, lft, tp, npix, choice;
    sent = 0;
    while (sent < n_items) begin
      choice = $urandom_range(0, 19);
      if (choice == 0) begin
        wait_drained();
      end else if (choice < 3) begin
        send_area($urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
        sent++;
        npix = $urandom_range(0, 5);
        repeat (npix) begin
          send_pixel(16'($urandom));
          sent++;
        end
      end else if (choice < 4) begin
        npix = $urandom_range(1, 4);
        repeat (npix) begin
          send_pixel(16'($urandom));
          sent++;
        end
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          w = $urandom_range(1, 32);
          h = $urandom_range(1, 4);
        end else begin
          w = $urandom_range(1, 6);
          h = $urandom_range(1, 6);
        end
        if ($urandom_range(0, 1) == 1) begin
          tmp = w;
          w = h;
          h = tmp;
        end
        lft = $urandom_range(0, 1024 - w);
        tp  = $urandom_range(0, 1024 - h);
        send_area(lft, tp, lft + w - 1, tp + h - 1);
        sent++;
        npix = w * h;
        // cut short or run past the area now and then
        case ($urandom_range(0, 7))
          0: npix = $urandom_range(0, npix - 1);
          1: npix = npix + $urandom_range(1, 3);
          default: ;
        endcase
        repeat (npix) begin
          send_pixel(16'($urandom));
          sent++;
        end
      end
    end
  endtask

  // Accept results with random stalls and check each one
  initial begin : result_sink
    int gap;
    m_axis_tready = 1'b0;
    sink_streak = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(sink_streak);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  initial begin : stimulus
    int unsigned p;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_streak   = 0;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: pixels before any area, full-size area, reversed area,
    // single pixel at the right edge, then a small area overrun by one pixel
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    send_area(0, 0, 1023, 1023);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    send_area(1023, 1023, 0, 0);
    send_pixel(16'hA5A5);
    send_pixel(16'h5A5A);
    send_area(1023, 0, 1023, 0);
    send_pixel(16'h1234);
    send_area(5, 7, 7, 8);
    repeat (7) send_pixel(16'($urandom));

    // Random phases, each under its own register settings
    for (p = 0; p < 10; p++) begin
      wait_drained();
      if (p < 6)
        program_settings(phase_rot[p], phase_step[p], phase_sw[p], phase_sh[p]);
      else
        program_settings(pars_pkg::rot_mode_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                         $urandom_range(1, 1024), $urandom_range(1, 1024));
      run_phase(108);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d area headers and %0d pixels across 11 register settings,",
             sb.areas_seen, sb.pixels_seen);
    $display("all rotation modes, step and screen extremes, reversed and overrun areas");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pars_pkg.sv
hw/rtl/pars_regs.sv
hw/rtl/pars_ctrl.sv
hw/rtl/pars_dp.sv
hw/rtl/partial_area_rotation_scatter_unit.sv
test/tb_partial_area_rotation_scatter_unit.sv
